// File: rtl/core/pps_pkg.sv
`default_nettype none

package pps_pkg;

  localparam int unsigned TimeW = 32;
  localparam logic [TimeW-1:0] TimeMax = '1;

  localparam logic ReqLoad = 1'b0;
  localparam logic ReqTick = 1'b1;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;      // latch the accepted request and clear the scan
    logic scan_issue;   // read the table entry at the scan pointer
    logic load_commit;  // write the loaded entry and post a zero result
    logic tick_commit;  // serve the winner and post its result
  } pps_cmd_t;

  typedef struct packed {
    logic req_tick;     // the latched request is a tick
    logic scan_last;    // the scan pointer sits on the last entry
    logic out_free;     // the result register can take a new result
  } pps_status_t;

endpackage

`default_nettype wire

// File: rtl/core/pps_ctrl.sv
`default_nettype none

module pps_ctrl
  import pps_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         in_valid_i,
  output logic        in_stall_o,
  input  pps_status_t status_i,
  output pps_cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_LOAD   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_COMMIT = 3'd4;

  logic [2:0] state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        // the latched type decides here whether a scan is needed
        if (status_i.req_tick) begin
          state_d = S_SCAN;
        end else if (status_i.out_free) begin
          cmd_o.load_commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (status_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last read entry is evaluated in this cycle
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (status_i.out_free) begin
          cmd_o.tick_commit = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.scan_issue |-> status_i.req_tick)
    else $error("scan running for a load request");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && status_i.scan_last) |=> (state_q == S_DRAIN))
    else $error("scan did not end after the last entry");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load_commit || cmd_o.tick_commit) |-> status_i.out_free)
    else $error("result posted while the result register is held");

endmodule

`default_nettype wire

// File: rtl/core/pps_datapath.sv
`default_nettype none

module pps_datapath
  import pps_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  pps_cmd_t         cmd_i,
  output pps_status_t      status_o,
  input  wire              cfg_valid_i,
  input  wire  [4:0]       cfg_data_i,
  input  wire              req_type_i,
  input  wire  [3:0]       entry_index_i,
  input  wire  [15:0]      arrival_time_i,
  input  wire  [15:0]      burst_length_i,
  input  wire  [7:0]       priority_level_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic             ran_valid_o,
  output logic [3:0]       ran_index_o,
  output logic             finished_o,
  output logic [TimeW-1:0] finish_time_o
);

  localparam int unsigned IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CmpW = ((IdxW > 5) ? IdxW : 5) + 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_PROCS - 1);

  // table storage
  logic [15:0] arr_mem [MAX_PROCS];
  logic [15:0] rem_mem [MAX_PROCS];
  logic [7:0]  pri_mem [MAX_PROCS];
  logic [MAX_PROCS-1:0] done_q;

  logic [4:0] active_count_q;

  // latched request
  logic        req_type_q;
  logic [3:0]  ld_idx_q;
  logic [15:0] ld_arr_q;
  logic [15:0] ld_burst_q;
  logic [7:0]  ld_pri_q;

  // scan pipeline
  logic [IdxW-1:0] scan_q;
  logic            ev_vld_q;
  logic [IdxW-1:0] ev_idx_q;
  logic [15:0]     rd_arr_q;
  logic [15:0]     rd_rem_q;
  logic [7:0]      rd_pri_q;

  // best candidate and running entry seen in the scan
  logic            found_q;
  logic [IdxW-1:0] best_idx_q;
  logic [15:0]     best_arr_q;
  logic [15:0]     best_rem_q;
  logic [7:0]      best_pri_q;
  logic            run_vld_q;
  logic [IdxW-1:0] run_idx_q;
  logic            run_elig_q;
  logic [7:0]      run_pri_q;
  logic [15:0]     run_rem_q;

  logic [TimeW-1:0] time_q;
  logic             out_valid_q;

  logic             elig;
  logic             better;
  logic             keep_run;
  logic [IdxW-1:0]  win_idx;
  logic [15:0]      win_rem_next;
  logic             win_done;
  logic [TimeW-1:0] time_next;
  logic             ld_in_range;

  assign ld_in_range = (32'(ld_idx_q) < MAX_PROCS);

  assign elig = ev_vld_q && (CmpW'(ev_idx_q) < CmpW'(active_count_q)) &&
                !done_q[ev_idx_q] && (rd_rem_q != 16'd0) &&
                ({16'd0, rd_arr_q} <= time_q);

  // running entry wins ties on priority, others go by arrival then index
  assign better = !found_q || (rd_pri_q < best_pri_q) ||
                  ((rd_pri_q == best_pri_q) && (rd_arr_q < best_arr_q));

  assign keep_run     = run_vld_q && run_elig_q && (run_pri_q == best_pri_q);
  assign win_idx      = keep_run ? run_idx_q : best_idx_q;
  assign win_rem_next = (keep_run ? run_rem_q : best_rem_q) - 16'd1;
  assign win_done     = (win_rem_next == 16'd0);
  assign time_next    = (time_q == TimeMax) ? TimeMax : time_q + 1'b1;

  assign status_o.req_tick  = (req_type_q == ReqTick);
  assign status_o.scan_last = (scan_q == LastIdx);
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_type_q <= req_type_i;
      ld_idx_q   <= entry_index_i;
      ld_arr_q   <= arrival_time_i;
      ld_burst_q <= burst_length_i;
      ld_pri_q   <= priority_level_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_commit && ld_in_range) begin
      arr_mem[IdxW'(ld_idx_q)] <= ld_arr_q;
      pri_mem[IdxW'(ld_idx_q)] <= ld_pri_q;
    end
    if (cmd_i.load_commit && ld_in_range) begin
      rem_mem[IdxW'(ld_idx_q)] <= ld_burst_q;
    end else if (cmd_i.tick_commit && found_q) begin
      rem_mem[win_idx] <= win_rem_next;
    end
    if (cmd_i.scan_issue) begin
      rd_arr_q <= arr_mem[scan_q];
      rd_rem_q <= rem_mem[scan_q];
      rd_pri_q <= pri_mem[scan_q];
    end
    ev_idx_q <= scan_q;
  end

  always_ff @(posedge clk_i) begin
    if (elig && better) begin
      best_idx_q <= ev_idx_q;
      best_arr_q <= rd_arr_q;
      best_rem_q <= rd_rem_q;
      best_pri_q <= rd_pri_q;
    end
    if (ev_vld_q && (ev_idx_q == run_idx_q)) begin
      run_elig_q <= elig;
      run_pri_q  <= rd_pri_q;
      run_rem_q  <= rd_rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_count_q <= '0;
      done_q         <= '0;
      scan_q         <= '0;
      ev_vld_q       <= 1'b0;
      found_q        <= 1'b0;
      run_vld_q      <= 1'b0;
      run_idx_q      <= '0;
      time_q         <= '0;
      out_valid_q    <= 1'b0;
      ran_valid_o    <= 1'b0;
      ran_index_o    <= '0;
      finished_o     <= 1'b0;
      finish_time_o  <= '0;
    end else begin
      if (cfg_valid_i) begin
        active_count_q <= cfg_data_i;
      end
      ev_vld_q <= cmd_i.scan_issue;
      if (cmd_i.capture) begin
        scan_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_issue) begin
          scan_q <= scan_q + 1'b1;
        end
        if (elig) begin
          found_q <= 1'b1;
        end
      end

      if (cmd_i.load_commit || cmd_i.tick_commit) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cmd_i.load_commit) begin
        if (ld_in_range) begin
          done_q[IdxW'(ld_idx_q)] <= (ld_burst_q == 16'd0);
        end
        ran_valid_o   <= 1'b0;
        ran_index_o   <= '0;
        finished_o    <= 1'b0;
        finish_time_o <= '0;
      end

      if (cmd_i.tick_commit) begin
        time_q      <= time_next;
        if (found_q) begin
          ran_valid_o <= 1'b1;
          ran_index_o <= 4'(win_idx);
          finished_o  <= win_done;
          finish_time_o <= win_done ? time_next : '0;
          if (win_done) begin
            done_q[win_idx] <= 1'b1;
            run_vld_q <= 1'b0;
            run_idx_q <= '0;
          end else begin
            run_vld_q <= 1'b1;
            run_idx_q <= win_idx;
          end
        end else begin
          ran_valid_o   <= 1'b0;
          ran_index_o   <= '0;
          finished_o    <= 1'b0;
          finish_time_o <= '0;
          run_vld_q     <= 1'b0;
          run_idx_q     <= '0;
        end
      end
    end
  end

  assign out_valid_o = out_valid_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.tick_commit |=>
      (time_q == $past(time_q) + 1'b1) || ($past(time_q) == TimeMax))
    else $error("time did not advance on a tick");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tick_commit && found_q && win_done) |=> done_q[$past(win_idx)])
    else $error("finished entry not marked done");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.tick_commit && found_q) |=> (run_vld_q == !$past(win_done)))
    else $error("running entry out of step with completion");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load_commit || cmd_i.tick_commit) |=> out_valid_q)
    else $error("result not posted after a commit");

endmodule

`default_nettype wire

// File: rtl/core/preemptive_priority_scheduler.sv
// a load is latched, then committed from S_LOAD; a tick is latched, then passes
//   S_LOAD, S_SCAN, S_DRAIN and S_COMMIT; each result is registered at commit
// one request at a time, taken in S_IDLE; the scan reads one table entry per cycle
// a waiting result lets the next request start, whose commit waits until it is taken
// reset: asynchronous active low; clears done flags, running entry, time and
//   active_count; table contents stay undefined until loaded
`default_nettype none

module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int unsigned MAX_PROCS = 16
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire  [4:0]       cfg_data_i,
  input  wire              in_valid_i,
  output logic             in_stall_o,
  input  wire              req_type_i,
  input  wire  [3:0]       entry_index_i,
  input  wire  [15:0]      arrival_time_i,
  input  wire  [15:0]      burst_length_i,
  input  wire  [7:0]       priority_level_i,
  output logic             out_valid_o,
  input  wire              out_stall_i,
  output logic             ran_valid_o,
  output logic [3:0]       ran_index_o,
  output logic             finished_o,
  output logic [TimeW-1:0] finish_time_o
);

  pps_cmd_t    cmd;
  pps_status_t status;

  assign cfg_ready_o = 1'b1;

  pps_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  pps_datapath #(
    .MAX_PROCS (MAX_PROCS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .entry_index_i    (entry_index_i),
    .arrival_time_i   (arrival_time_i),
    .burst_length_i   (burst_length_i),
    .priority_level_i (priority_level_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .ran_valid_o      (ran_valid_o),
    .ran_index_o      (ran_index_o),
    .finished_o       (finished_o),
    .finish_time_o    (finish_time_o)
  );

endmodule

`default_nettype wire
